// ===== rtl/srks_pkg.sv =====
// shared constants and types for the sorted record key search block
package srks_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int KEY_BYTES   = 14;
    localparam int KEY_W       = 112;
    localparam int COUNT_W     = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int TOTAL_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CB_W        = 3;
    localparam logic [CB_W-1:0] COUNT_BYTES_RESET = 3'd2;

    // only the KEY_BYTES most significant bytes take part in the compare
    localparam logic [KEY_W-1:0] KEY_MASK =
        {KEY_W{1'b1}} << (8 * (14 - KEY_BYTES));

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } record_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        record_t           data;
    } wr_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

endpackage

// ===== rtl/srks_store.sv =====
// record memory: one write port, one read port with registered data
module srks_store
(
    input  logic            clk,
    input  srks_pkg::wr_req_t wr,
    input  srks_pkg::rd_req_t rd,
    output srks_pkg::record_t rd_data
);
    import srks_pkg::*;

    record_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

// ===== rtl/sorted_record_key_search.sv =====
// top level of the sorted record key search block
//
// Holds up to 2048 records of a 112-bit key and a 32-bit count in one
// single-port-read memory. Items are taken one at a time. A clear, an append
// or an unused opcode gives its result through the EXEC and FINISH states.
// A query runs a binary search where each probe is a memory read (PROBE
// state), then a key compare (COMPARE state), with at most ceil(log2(n+1))
// probes over n records.
// The next item is taken while a result still waits in the output register.
// Records must be appended in ascending key order; this is not checked.
// No clearing pass is needed after reset.
module sorted_record_key_search
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_data,   // count_bytes
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,       // key_high[47:0], key_low[111:48], count_value[143:112]
    input  logic [1:0]   s_tuser,       // opcode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,       // found[0], hit_count[32:1], zero[39:33]
    output logic [0:0]   m_tuser        // status[0]
);
    import srks_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PROBE,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [CB_W-1:0]    count_bytes_reg;
    logic [TOTAL_W-1:0] total_reg;
    opcode_t            op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TOTAL_W-1:0] lo_reg;
    logic [TOTAL_W-1:0] hi_reg;
    logic [ADDR_W-1:0]  mid_reg;
    logic               res_status_reg;
    logic               res_found_reg;
    logic [COUNT_W-1:0] res_hit_reg;
    logic               m_tvalid_reg;
    logic               m_status_reg;
    logic               m_found_reg;
    logic [COUNT_W-1:0] m_hit_reg;

    wr_req_t            wr;
    rd_req_t            rd;
    record_t            rd_data;
    logic [TOTAL_W:0]   mid_sum;
    logic [ADDR_W-1:0]  mid;
    logic               span_left;
    logic               table_full;
    logic [KEY_W-1:0]   stored_key;
    logic               key_eq;
    logic               key_lt;
    logic               out_free;

    // masked count, zero reported as one
    function automatic logic [COUNT_W-1:0] hit_value(logic [COUNT_W-1:0] raw,
                                                     logic [CB_W-1:0] cb);
        logic [COUNT_W-1:0] v;
        case (cb)
            3'd0:    v = '0;
            3'd1:    v = {{(COUNT_W-8){1'b0}}, raw[7:0]};
            3'd2:    v = {{(COUNT_W-16){1'b0}}, raw[15:0]};
            3'd3:    v = {{(COUNT_W-24){1'b0}}, raw[23:0]};
            default: v = raw;
        endcase
        if (v == '0)
        begin
            v = COUNT_W'(1);
        end
        return v;
    endfunction

    assign table_full = (total_reg == TOTAL_W'(TABLE_DEPTH));
    assign span_left  = (lo_reg < hi_reg);
    // mid = (first + last) / 2 with last = hi - 1
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - (TOTAL_W+1)'(1);
    assign mid        = mid_sum[ADDR_W:1];

    assign stored_key = rd_data.key & KEY_MASK;
    assign key_eq     = (stored_key == key_reg);
    assign key_lt     = (stored_key < key_reg);

    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        wr.en      = (state_reg == ST_EXEC) && (op_reg == OP_APPEND) && !table_full;
        wr.addr    = total_reg[ADDR_W-1:0];
        wr.data.key   = key_reg;
        wr.data.count = count_reg;
        rd.en      = (state_reg == ST_PROBE) && span_left;
        rd.addr    = mid;
    end

    srks_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_bytes_reg <= COUNT_BYTES_RESET;
            total_reg       <= '0;
            op_reg          <= OP_NONE;
            key_reg         <= '0;
            count_reg       <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            mid_reg         <= '0;
            res_status_reg  <= 1'b0;
            res_found_reg   <= 1'b0;
            res_hit_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
            m_status_reg    <= 1'b0;
            m_found_reg     <= 1'b0;
            m_hit_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_bytes_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= opcode_t'(s_tuser);
                        key_reg   <= {s_tdata[47:0], s_tdata[111:48]};
                        count_reg <= s_tdata[143:112];
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    res_status_reg <= (op_reg == OP_APPEND) && table_full;
                    res_found_reg  <= 1'b0;
                    res_hit_reg    <= '0;
                    unique case (op_reg)
                        OP_CLEAR:
                        begin
                            total_reg <= '0;
                            state_reg <= ST_FINISH;
                        end
                        OP_APPEND:
                        begin
                            if (!table_full)
                            begin
                                total_reg <= total_reg + TOTAL_W'(1);
                            end
                            state_reg <= ST_FINISH;
                        end
                        OP_QUERY:
                        begin
                            key_reg   <= key_reg & KEY_MASK;
                            lo_reg    <= '0;
                            hi_reg    <= total_reg;
                            state_reg <= ST_PROBE;
                        end
                        default:
                        begin
                            state_reg <= ST_FINISH;
                        end
                    endcase
                end
                ST_PROBE:
                begin
                    mid_reg <= mid;
                    if (span_left)
                    begin
                        state_reg <= ST_COMPARE;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_COMPARE:
                begin
                    if (key_eq)
                    begin
                        res_found_reg <= 1'b1;
                        res_hit_reg   <= hit_value(rd_data.count, count_bytes_reg);
                        state_reg     <= ST_FINISH;
                    end
                    else
                    begin
                        if (key_lt)
                        begin
                            lo_reg <= TOTAL_W'(mid_reg) + TOTAL_W'(1);
                        end
                        else
                        begin
                            hi_reg <= TOTAL_W'(mid_reg);
                        end
                        state_reg <= ST_PROBE;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_found_reg  <= res_found_reg;
                        m_hit_reg    <= res_hit_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {7'd0, m_hit_reg, m_found_reg};
    assign m_tuser[0] = m_status_reg;

endmodule

// ===== rtl/srks_checker.sv =====
// port-level checks for the sorted record key search block
module srks_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata,
    input logic [0:0]   m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item at a time: ready drops after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is at work");

    // a refused append never reports a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tdata[0]))
        else $error("status and found both set");

    // a hit always reports a nonzero count, a miss reports zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[32:1] != 32'd0)))
        else $error("hit_count disagrees with found");

endmodule

bind sorted_record_key_search srks_checker u_srks_checker (.*);

// ===== sim/tb_top.sv =====
// testbench for the sorted record key search block: sorted tables, lookups, noise items
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srks_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 400;

    typedef struct {
        opcode_t     op;
        logic [47:0] key_high;
        logic [63:0] key_low;
        logic [31:0] count_value;
    } table_op_t;

    typedef struct {
        logic        status;
        logic        found;
        logic [31:0] hit_count;
    } lookup_answer_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic [0:0]   m_tuser;

    sorted_record_key_search u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // testbench copy of the table
    logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0] count_mem [TABLE_DEPTH];
    int                 record_count;
    logic [2:0]         count_bytes_now;

    table_op_t      pending_items [$];
    lookup_answer_t answer_queue [$];
    table_op_t      bus_item;
    logic [KEY_W-1:0] loaded_keys [$];

    int  issued_count;
    int  accepted_count;
    int  answers_checked;
    int  mismatches;
    int  items_sent;
    int  queries_taken;
    int  hits_seen;
    int  refused_seen;
    int  cfg_writes;
    int  quiet_cycles;
    int  src_gap;
    int  sink_stall;
    bit  src_gap_on;
    bit  sink_stall_on;
    bit  timed_out;
    bit  stim_done;

    function automatic lookup_answer_t apply_table_op(input table_op_t it);
        lookup_answer_t   ans;
        logic [KEY_W-1:0] probe;
        logic [KEY_W-1:0] stored;
        logic [31:0]      v;
        int               first;
        int               last;
        int               mid;
        int               nb;
        bit               hit_done;
        ans = '{default: '0};
        case (it.op)
            OP_CLEAR: record_count = 0;
            OP_APPEND:
            begin
                if (record_count >= TABLE_DEPTH)
                    ans.status = 1'b1;
                else
                begin
                    key_mem[record_count]   = {it.key_high, it.key_low};
                    count_mem[record_count] = it.count_value;
                    record_count++;
                end
            end
            OP_QUERY:
            begin
                probe    = {it.key_high, it.key_low} & KEY_MASK;
                first    = 0;
                last     = record_count - 1;
                hit_done = 0;
                while (first <= last && !hit_done)
                begin
                    mid    = (first + last) / 2;
                    stored = key_mem[mid] & KEY_MASK;
                    if (stored == probe)
                    begin
                        hit_done = 1;
                        nb = (count_bytes_now > 3'd4) ? 4 : int'(count_bytes_now);
                        v  = count_mem[mid];
                        if (nb == 0)
                            v = 32'd1;
                        else
                        begin
                            if (nb < 4)
                                v = v & ((32'd1 << (8 * nb)) - 32'd1);
                            if (v == 32'd0)
                                v = 32'd1;
                        end
                        ans.found     = 1'b1;
                        ans.hit_count = v;
                    end
                    else if (stored < probe)
                        first = mid + 1;
                    else
                        last = mid - 1;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // source side: new item after acceptance, with optional gaps
    always @(negedge clk)
    begin
        if (s_tvalid && issued_count != accepted_count)
            ;
        else if (src_gap > 0)
        begin
            src_gap = src_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (pending_items.size() > 0)
        begin
            bus_item = pending_items.pop_front();
            s_tdata  <= {bus_item.count_value, bus_item.key_low, bus_item.key_high};
            s_tuser  <= bus_item.op;
            s_tvalid <= 1'b1;
            issued_count++;
            if (src_gap_on && $urandom_range(0, 3) == 0)
                src_gap = $urandom_range(1, 10);
        end
        else
            s_tvalid <= 1'b0;
    end

    // sink side: ready with random stall bursts
    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall = sink_stall - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (sink_stall_on && $urandom_range(0, 5) == 0)
                sink_stall = $urandom_range(1, 10);
        end
    end

    always @(posedge clk)
    begin
        lookup_answer_t want;
        lookup_answer_t got;
        bit             moved;
        moved = 0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                answer_queue.push_back(apply_table_op(bus_item));
                accepted_count++;
                if (bus_item.op == OP_QUERY)
                    queries_taken++;
                moved = 1;
            end
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tuser[0];
                got.found     = m_tdata[0];
                got.hit_count = m_tdata[32:1];
                moved = 1;
                answers_checked++;
                if (answer_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d found %0d count %h",
                                 got.status, got.found, got.hit_count);
                end
                else
                begin
                    want = answer_queue.pop_front();
                    hits_seen    += want.found;
                    refused_seen += want.status;
                    if (got.status != want.status || got.found != want.found ||
                        got.hit_count != want.hit_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d wrong: expected status %0d found %0d count %h",
                                     answers_checked, want.status, want.found,
                                     want.hit_count);
                            $display("    got status %0d found %0d count %h",
                                     got.status, got.found, got.hit_count);
                        end
                    end
                end
            end
            if (moved || (pending_items.size() == 0 && issued_count == accepted_count &&
                          answer_queue.size() == 0))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                    timed_out = 1;
            end
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        return KEY_W'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return $urandom & 32'hFF00_FF00;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input opcode_t op, input logic [KEY_W-1:0] key,
                             input logic [31:0] cnt);
        table_op_t it;
        it.op          = op;
        it.key_high    = key[111:64];
        it.key_low     = key[63:0];
        it.count_value = cnt;
        pending_items.push_back(it);
        if (op != OP_NONE)
            items_sent++;
        if (op == OP_APPEND)
            loaded_keys.push_back(key);
        if (op == OP_CLEAR)
            loaded_keys.delete();
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || issued_count != accepted_count ||
               answer_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_count_bytes(input logic [2:0] v);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        count_bytes_now = v;
        cfg_writes++;
    endtask

    // ascending keys with gaps of very different sizes, start kept low so no wrap
    task automatic load_sorted(input int n, input bit with_noise);
        logic [KEY_W-1:0] k;
        k = pick_key() >> $urandom_range(4, 100);
        for (int i = 0; i < n; i++)
        begin
            push_item(OP_APPEND, k, pick_count());
            if (with_noise && $urandom_range(0, 15) == 0)
                push_item(OP_NONE, pick_key(), $urandom);
            case ($urandom_range(0, 2))
                0: k = k + KEY_W'($urandom_range(1, 4));
                1: k = k + KEY_W'({$urandom}) + KEY_W'(1);
                default: k = k + ({80'd0, $urandom} << $urandom_range(32, 64)) + KEY_W'(1);
            endcase
        end
    endtask

    task automatic random_queries(input int m);
        logic [KEY_W-1:0] k;
        int               r;
        for (int i = 0; i < m; i++)
        begin
            r = $urandom_range(0, 9);
            if (loaded_keys.size() == 0 || r == 7)
                push_item(OP_QUERY, pick_key(), $urandom);
            else if (r <= 5)
                push_item(OP_QUERY, loaded_keys[$urandom_range(0, loaded_keys.size() - 1)],
                          $urandom);
            else if (r == 6)
            begin
                k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
                push_item(OP_QUERY, $urandom_range(0, 1) ? k + KEY_W'(1) : k - KEY_W'(1),
                          $urandom);
            end
            else if (r == 8)
            begin
                // noise: unused opcode or an append that breaks the order
                if ($urandom_range(0, 1))
                    push_item(OP_NONE, pick_key(), $urandom);
                else
                    push_item(OP_APPEND, pick_key(), pick_count());
            end
            else
                push_item(OP_QUERY, $urandom_range(0, 1) ? loaded_keys[0] : loaded_keys[$],
                          $urandom);
        end
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 3'd0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        record_count  = 0;
        count_bytes_now = COUNT_BYTES_RESET;
        src_gap_on    = 1;
        sink_stall_on = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, zero counts, unsorted and duplicate keys
        push_item(OP_QUERY, '0, '0);
        push_item(OP_NONE, {KEY_W{1'b1}}, 32'hFFFF_FFFF);
        push_item(OP_APPEND, '0, 32'd0);
        push_item(OP_APPEND, 112'd5, 32'h1234_5678);
        push_item(OP_APPEND, 112'd1 << 64, 32'hABCD_0000);
        push_item(OP_APPEND, {KEY_W{1'b1}}, 32'hFFFF_FFFF);
        push_item(OP_QUERY, '0, 32'hFFFF_FFFF);
        push_item(OP_QUERY, 112'd5, '0);
        push_item(OP_QUERY, 112'd1 << 64, '0);
        push_item(OP_QUERY, {KEY_W{1'b1}}, '0);
        push_item(OP_QUERY, 112'd4, '0);
        push_item(OP_QUERY, {{(KEY_W-1){1'b1}}, 1'b0}, '0);
        push_item(OP_APPEND, 112'd9, 32'h0000_0042);
        push_item(OP_QUERY, 112'd9, '0);
        push_item(OP_APPEND, 112'd5, 32'h0000_0077);
        push_item(OP_QUERY, 112'd5, '0);
        push_item(OP_CLEAR, {KEY_W{1'b1}}, 32'hFFFF_FFFF);
        push_item(OP_QUERY, 112'd5, '0);
        push_item(OP_APPEND, 112'd3, 32'h0000_0100);
        push_item(OP_APPEND, 112'd1, 32'h0001_0000);
        push_item(OP_QUERY, 112'd1, '0);
        push_item(OP_QUERY, 112'd3, '0);

        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            write_count_bytes(3'(phase % 8));
            src_gap_on    = ($urandom_range(0, 3) != 0);
            sink_stall_on = ($urandom_range(0, 3) != 0);
            push_item(OP_CLEAR, pick_key(), $urandom);
            if ($urandom_range(0, 3) == 0)
                push_item(OP_QUERY, pick_key(), $urandom);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
            load_sorted(n, 1);
            random_queries(n + $urandom_range(4, 24));
            phase++;
        end

        // last part with no idling: a longer table and back-to-back lookups
        write_count_bytes(3'd4);
        src_gap_on    = 0;
        sink_stall_on = 0;
        push_item(OP_CLEAR, '0, '0);
        load_sorted(48, 0);
        random_queries(40);
        push_item(OP_CLEAR, '0, '0);
        push_item(OP_QUERY, '0, '0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done || timed_out);
        mismatches += answer_queue.size();
        $display("ran %0d items over %0d count_bytes settings: %0d queries, %0d hits",
                 accepted_count, cfg_writes + 1, queries_taken, hits_seen);
        $display("%0d results checked, %0d appends refused, timeout %0d",
                 answers_checked, refused_seen, timed_out);
        if (!timed_out && mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
